>>> sv/twk_pkg.sv
// shared types, codes and constants of the twinkle star envelope unit
package twk_pkg;

  // default number of leds with envelope state
  localparam int unsigned LedSlotsDefault = 256;

  // field widths
  localparam int unsigned LedW   = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RollW  = 10;
  localparam int unsigned DurW   = 16;
  localparam int unsigned ColW   = 8;
  localparam int unsigned NumCol = 3;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHold      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFade      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRed       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgGreen     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgBlue      = 3'd5;

  // register reset values
  localparam logic [RollW-1:0] ThresholdReset = 10'd50;
  localparam logic [DurW-1:0]  HoldReset      = 16'd500;
  localparam logic [DurW-1:0]  FadeReset      = 16'd500;
  localparam logic [ColW-1:0]  ColReset       = 8'd255;

  // item kinds
  localparam logic KindSpawn  = 1'b0;
  localparam logic KindRender = 1'b1;

  // divider: one quotient bit per step, quotient fits a color level
  localparam int unsigned DivSteps = ColW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [2:0] {
    StIdle,
    StLookup,
    StEval,
    StPhase,
    StMul,
    StDiv,
    StDone
  } twk_state_e;

  typedef struct packed {
    logic capture;
    logic spawn;
    logic elapsed;
    logic phase;
    logic mul;
    logic div_step;
    logic load_out;
  } twk_cmd_t;

  typedef struct packed {
    logic is_render;
    logic scale;
  } twk_status_t;

endpackage

>>> sv/twinkle_star_envelope_unit.sv
// twinkle star envelope unit: per-led fade-in, hold, fade-out color scaling
// a spawn request frees the input after its lookup step; a render request goes through lookup,
// eval and phase, during a fade also multiply and an 8-step divide, then loads its pixel and
// frees the input once the output register is free; one request is in work at a time; the output
// register lets the next request in while a pixel still waits to be taken
// reset (async, active low) clears all active flags, restores the register defaults
module twinkle_star_envelope_unit #(
  parameter int unsigned LED_SLOTS = twk_pkg::LedSlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [twk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [twk_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_kind_i,
  input  logic [twk_pkg::LedW-1:0]     in_led_index_i,
  input  logic [twk_pkg::TimeW-1:0]    in_now_ms_i,
  input  logic [twk_pkg::RollW-1:0]    in_roll_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [twk_pkg::LedW-1:0]     out_pixel_index_o,
  output logic [twk_pkg::ColW-1:0]     out_pixel_red_o,
  output logic [twk_pkg::ColW-1:0]     out_pixel_green_o,
  output logic [twk_pkg::ColW-1:0]     out_pixel_blue_o
);
  import twk_pkg::*;

  twk_cmd_t    cmd;
  twk_status_t status;

  assign cfg_ready_o = 1'b1;

  twk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  twk_datapath #(
    .LED_SLOTS (LED_SLOTS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_kind_i         (in_kind_i),
    .in_led_index_i    (in_led_index_i),
    .in_now_ms_i       (in_now_ms_i),
    .in_roll_i         (in_roll_i),
    .out_pixel_index_o (out_pixel_index_o),
    .out_pixel_red_o   (out_pixel_red_o),
    .out_pixel_green_o (out_pixel_green_o),
    .out_pixel_blue_o  (out_pixel_blue_o)
  );

endmodule

>>> sv/twk_ctrl.sv
// sequencer of the envelope unit: handshakes, item steps and divide count
module twk_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  twk_pkg::twk_status_t status_i,
  output twk_pkg::twk_cmd_t    cmd_o
);
  import twk_pkg::*;

  twk_state_e         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StLookup;
      end
      StLookup: begin
        state_d = status_i.is_render ? StEval : StIdle;
      end
      StEval:  state_d = StPhase;
      StPhase: state_d = status_i.scale ? StMul : StDone;
      StMul:   state_d = StDiv;
      StDiv: begin
        if (cnt_q == DivCntW'(DivSteps - 1)) state_d = StDone;
      end
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd_o       = '0;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      StIdle:   cmd_o.capture = in_valid_i;
      StLookup: cmd_o.spawn = !status_i.is_render;
      StEval:   cmd_o.elapsed = 1'b1;
      StPhase:  cmd_o.phase = 1'b1;
      StMul: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      StDone: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/twk_datapath.sv
// envelope datapath: registers, per-led state, scaling multiply and divide
module twk_datapath #(
  parameter int unsigned LED_SLOTS = twk_pkg::LedSlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  twk_pkg::twk_cmd_t            cmd_i,
  output twk_pkg::twk_status_t         status_o,
  input  logic                         cfg_we_i,
  input  logic [twk_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [twk_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_kind_i,
  input  logic [twk_pkg::LedW-1:0]     in_led_index_i,
  input  logic [twk_pkg::TimeW-1:0]    in_now_ms_i,
  input  logic [twk_pkg::RollW-1:0]    in_roll_i,
  output logic [twk_pkg::LedW-1:0]     out_pixel_index_o,
  output logic [twk_pkg::ColW-1:0]     out_pixel_red_o,
  output logic [twk_pkg::ColW-1:0]     out_pixel_green_o,
  output logic [twk_pkg::ColW-1:0]     out_pixel_blue_o
);
  import twk_pkg::*;

  // only leds reachable by an 8-bit index carry state
  localparam int unsigned LedSpan = 1 << LedW;
  localparam int unsigned Depth   = (LED_SLOTS < LedSpan) ? LED_SLOTS : LedSpan;
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ProdW   = ColW + DurW;

  // configuration
  logic [RollW-1:0] thr_q;
  logic [DurW-1:0]  hold_q, fade_q;
  logic [ColW-1:0]  col_q [NumCol];

  // item
  logic             kind_q;
  logic [LedW-1:0]  led_q;
  logic [TimeW-1:0] now_q;
  logic [RollW-1:0] roll_q;
  logic [AddrW-1:0] addr;
  logic             in_range;

  // per-led state
  logic [Depth-1:0] active_q;
  logic [TimeW-1:0] start_mem [Depth];
  logic [TimeW-1:0] start_rd_q;

  // envelope
  logic [TimeW-1:0] e_q;
  logic             hit_q;
  logic [DurW:0]    plateau_end;
  logic [DurW+1:0]  total;
  logic [DurW+1:0]  left;
  logic             expired, lt_fade, lt_plateau_end, show;
  logic [DurW-1:0]  num_q;

  // scaling
  logic [DurW-1:0]  rem_q [NumCol];
  logic [ColW-1:0]  lvl_q [NumCol];
  logic [ProdW-1:0] prod  [NumCol];
  logic [DurW:0]    trial [NumCol];
  logic [DurW:0]    diff  [NumCol];
  logic             ge    [NumCol];

  logic             spawn_ok;

  // output
  logic [LedW-1:0]  out_idx_q;
  logic [ColW-1:0]  out_col_q [NumCol];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThresholdReset;
      hold_q <= HoldReset;
      fade_q <= FadeReset;
      for (int k = 0; k < NumCol; k++) col_q[k] <= ColReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgThreshold: thr_q    <= cfg_data_i[RollW-1:0];
        CfgHold:      hold_q   <= cfg_data_i[DurW-1:0];
        CfgFade:      fade_q   <= cfg_data_i[DurW-1:0];
        CfgRed:       col_q[0] <= cfg_data_i[ColW-1:0];
        CfgGreen:     col_q[1] <= cfg_data_i[ColW-1:0];
        CfgBlue:      col_q[2] <= cfg_data_i[ColW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_kind_i;
      led_q  <= in_led_index_i;
      now_q  <= in_now_ms_i;
      roll_q <= in_roll_i;
    end
  end

  assign in_range = (32'(led_q) < LED_SLOTS);
  assign addr     = led_q[AddrW-1:0];
  assign spawn_ok = cmd_i.spawn && (roll_q < thr_q) && in_range && !active_q[addr];

  // start time store, read data registered
  always_ff @(posedge clk_i) begin
    if (spawn_ok) start_mem[addr] <= now_q;
    start_rd_q <= start_mem[addr];
  end

  // envelope boundaries
  assign plateau_end    = {1'b0, fade_q} + {1'b0, hold_q};
  assign total          = {1'b0, plateau_end} + {2'b0, fade_q};
  assign expired        = (e_q >= {{(TimeW-DurW-2){1'b0}}, total});
  assign lt_fade        = (e_q < {{(TimeW-DurW){1'b0}}, fade_q});
  assign lt_plateau_end = (e_q < {{(TimeW-DurW-1){1'b0}}, plateau_end});
  assign left           = total - e_q[DurW+1:0];
  assign show           = hit_q && !expired;

  assign status_o.is_render = (kind_q == KindRender);
  assign status_o.scale     = show && (lt_fade || !lt_plateau_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (spawn_ok) begin
      active_q[addr] <= 1'b1;
    end else if (cmd_i.phase && hit_q && expired) begin
      active_q[addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.elapsed) begin
      e_q   <= now_q - start_rd_q;
      hit_q <= in_range && active_q[addr];
    end
    if (cmd_i.phase) begin
      // fade-out level counts down from the end of life
      num_q <= lt_fade ? e_q[DurW-1:0] : left[DurW-1:0];
    end
  end

  // restoring divide by fade time, dividend high part is already below it
  always_comb begin
    for (int k = 0; k < NumCol; k++) begin
      prod[k]  = ProdW'(col_q[k]) * ProdW'(num_q);
      trial[k] = {rem_q[k], lvl_q[k][ColW-1]};
      ge[k]    = (trial[k] >= {1'b0, fade_q});
      diff[k]  = trial[k] - {1'b0, fade_q};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumCol; k++) begin
      if (cmd_i.phase) begin
        lvl_q[k] <= show ? col_q[k] : '0;
      end else if (cmd_i.mul) begin
        rem_q[k] <= prod[k][ProdW-1:ColW];
        lvl_q[k] <= prod[k][ColW-1:0];
      end else if (cmd_i.div_step) begin
        rem_q[k] <= ge[k] ? diff[k][DurW-1:0] : trial[k][DurW-1:0];
        lvl_q[k] <= {lvl_q[k][ColW-2:0], ge[k]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_idx_q <= led_q;
      for (int k = 0; k < NumCol; k++) out_col_q[k] <= lvl_q[k];
    end
  end

  assign out_pixel_index_o = out_idx_q;
  assign out_pixel_red_o   = out_col_q[0];
  assign out_pixel_green_o = out_col_q[1];
  assign out_pixel_blue_o  = out_col_q[2];

endmodule
